// ===== hw/rtl/csq_pkg.sv =====
// ----------------------------------------------------------------------------
// csq_pkg
// Shared types and constants for the counting semaphore with its wait queue.
// ----------------------------------------------------------------------------
package csq_pkg;

   localparam int DEF_WAITER_SLOTS = 32;
   localparam int DEF_ID_BITS      = 8;

   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

   localparam logic [FUNC_W-1:0] FUNC_WAIT     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_TRY_WAIT = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SIGNAL   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_WITHDRAW = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CANCEL   = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_ACQUIRED   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_QUEUED     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_TRY_FAILED = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL       = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_RAISED     = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_WOKEN      = 3'd5;
   localparam logic [STATUS_W-1:0] STATUS_WITHDRAWN  = 3'd6;
   localparam logic [STATUS_W-1:0] STATUS_CANCELLED  = 3'd7;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_LOAD,
      CELL_CANCEL
   } cell_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIGNAL,
      ST_WITHDRAW,
      ST_POP,
      ST_EMIT
   } state_type;

endpackage

// ===== hw/rtl/csq_cell.sv =====
// ----------------------------------------------------------------------------
// csq_cell
// One wait queue slot: valid bit and thread id, shifts toward the head.
// ----------------------------------------------------------------------------
module csq_cell #(
   parameter int ID_BITS = csq_pkg::DEF_ID_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  csq_pkg::cell_op_type op,
   input  logic [ID_BITS-1:0]  key,
   input  logic                shift_valid,
   input  logic [ID_BITS-1:0]  shift_id,
   output logic                valid,
   output logic [ID_BITS-1:0]  id,
   output logic                match
);

   logic               valid_ff, valid_in;
   logic [ID_BITS-1:0] id_ff, id_in;

   assign match = valid_ff && (id_ff == key);
   assign valid = valid_ff;
   assign id    = id_ff;

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      case (op)
         csq_pkg::CELL_HOLD: begin
         end
         csq_pkg::CELL_SHIFT: begin
            valid_in = shift_valid;
            id_in    = shift_id;
         end
         csq_pkg::CELL_LOAD: begin
            valid_in = 1'b1;
            id_in    = key;
         end
         csq_pkg::CELL_CANCEL: begin
            if (match) begin
               valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      id_ff <= id_in;
   end

endmodule

// ===== hw/rtl/counting_semaphore_wait_queue.sv =====
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue
// Counting semaphore with a FIFO of waiting thread ids held in a cell chain.
// ----------------------------------------------------------------------------
// Path from accept to result beat: wait, try wait and cancel go straight to EMIT.
// Signal passes through SIGNAL, popping cancelled slots at the head, then EMIT.
// Withdraw makes one full rotation of the slot chain in WITHDRAW, then POP when
// the head slot is popped, then EMIT. One item in flight; ready again the
// cycle after the result is loaded into the output register.
// Reset: synchronous; count 0, all slots empty, no clearing pass.
module counting_semaphore_wait_queue #(
   parameter int WAITER_SLOTS = csq_pkg::DEF_WAITER_SLOTS,
   parameter int ID_BITS      = csq_pkg::DEF_ID_BITS,
   localparam int REQ_W = ((csq_pkg::FUNC_W + ID_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((csq_pkg::STATUS_W + ID_BITS + csq_pkg::COUNT_W + 7) / 8) * 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [REQ_W-1:0]            req_tdata,   // func, thread_id
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [RSP_W-1:0]            rsp_tdata,   // status, woken_thread, count_after
   input  logic                        csr_wr_en,
   input  logic [csq_pkg::COUNT_W-1:0] csr_wr_data
);

   localparam int OCC_W  = $clog2(WAITER_SLOTS + 1);
   localparam int STEP_W = $clog2(WAITER_SLOTS);
   localparam int FW     = csq_pkg::FUNC_W;
   localparam int SW     = csq_pkg::STATUS_W;
   localparam int CW     = csq_pkg::COUNT_W;

   csq_pkg::state_type state_ff, state_in;

   logic [CW-1:0]      sem_ff, sem_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               found_ff, found_in;
   logic               pop_ff, pop_in;
   logic [ID_BITS-1:0] tid_ff, tid_in;
   logic [SW-1:0]      res_status_ff, res_status_in;
   logic [ID_BITS-1:0] res_woken_ff, res_woken_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]      rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0] rsp_woken_ff, rsp_woken_in;
   logic [CW-1:0]      rsp_count_ff, rsp_count_in;

   logic [FW-1:0]      req_func;
   logic [ID_BITS-1:0] req_tid;
   logic               accept;
   logic               out_free;
   logic               last_step;
   logic               kill;

   logic               do_shift, do_load, do_cancel;
   logic               tail_valid;
   logic [ID_BITS-1:0] key;

   logic [WAITER_SLOTS-1:0] cell_valid;
   logic [WAITER_SLOTS-1:0] cell_match;
   logic [ID_BITS-1:0]      cell_id [WAITER_SLOTS];

   assign req_func   = req_tdata[FW-1:0];
   assign req_tid    = req_tdata[FW +: ID_BITS];
   assign req_tready = (state_ff == csq_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_step  = (step_ff == STEP_W'(WAITER_SLOTS - 1));
   assign kill       = !found_ff && cell_match[0];
   assign key        = (state_ff == csq_pkg::ST_IDLE) ? req_tid : tid_ff;

   // slot chain, head at cell 0
   for (genvar k = 0; k < WAITER_SLOTS; k++) begin : g_cell
      csq_pkg::cell_op_type op;
      logic                 sh_valid;
      logic [ID_BITS-1:0]   sh_id;

      always_comb begin
         if (do_shift) begin
            op = csq_pkg::CELL_SHIFT;
         end else if (do_cancel) begin
            op = csq_pkg::CELL_CANCEL;
         end else if (do_load && (occ_ff == OCC_W'(k))) begin
            op = csq_pkg::CELL_LOAD;
         end else begin
            op = csq_pkg::CELL_HOLD;
         end
      end

      if (k == WAITER_SLOTS - 1) begin : g_tail
         assign sh_valid = tail_valid;
         assign sh_id    = cell_id[0];
      end else begin : g_body
         assign sh_valid = cell_valid[k+1];
         assign sh_id    = cell_id[k+1];
      end

      csq_cell #(
         .ID_BITS (ID_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .key         (key),
         .shift_valid (sh_valid),
         .shift_id    (sh_id),
         .valid       (cell_valid[k]),
         .id          (cell_id[k]),
         .match       (cell_match[k])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         csq_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_func == csq_pkg::FUNC_SIGNAL) begin
                  state_in = csq_pkg::ST_SIGNAL;
               end else if (req_func == csq_pkg::FUNC_WITHDRAW) begin
                  state_in = csq_pkg::ST_WITHDRAW;
               end else begin
                  state_in = csq_pkg::ST_EMIT;
               end
            end
         end
         csq_pkg::ST_SIGNAL: begin
            if (occ_ff == '0 || cell_valid[0]) begin
               state_in = csq_pkg::ST_EMIT;
            end
         end
         csq_pkg::ST_WITHDRAW: begin
            if (last_step) begin
               state_in = pop_ff ? csq_pkg::ST_POP : csq_pkg::ST_EMIT;
            end
         end
         csq_pkg::ST_POP: begin
            state_in = csq_pkg::ST_EMIT;
         end
         csq_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = csq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = csq_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath control
   always_comb begin
      sem_in        = sem_ff;
      occ_in        = occ_ff;
      step_in       = step_ff;
      found_in      = found_ff;
      pop_in        = pop_ff;
      tid_in        = tid_ff;
      res_status_in = res_status_ff;
      res_woken_in  = res_woken_ff;
      do_shift      = 1'b0;
      do_load       = 1'b0;
      do_cancel     = 1'b0;
      tail_valid    = 1'b0;
      case (state_ff)
         csq_pkg::ST_IDLE: begin
            if (accept) begin
               tid_in        = req_tid;
               step_in       = '0;
               found_in      = 1'b0;
               pop_in        = 1'b0;
               res_woken_in  = '0;
               res_status_in = csq_pkg::STATUS_TRY_FAILED;
               case (req_func)
                  csq_pkg::FUNC_WAIT, csq_pkg::FUNC_TRY_WAIT: begin
                     if (sem_ff != '0) begin
                        sem_in        = sem_ff - CW'(1);
                        res_status_in = csq_pkg::STATUS_ACQUIRED;
                     end else if (req_func == csq_pkg::FUNC_TRY_WAIT) begin
                        res_status_in = csq_pkg::STATUS_TRY_FAILED;
                     end else if (occ_ff == OCC_W'(WAITER_SLOTS)) begin
                        res_status_in = csq_pkg::STATUS_FULL;
                     end else begin
                        do_load       = 1'b1;
                        occ_in        = occ_ff + OCC_W'(1);
                        res_status_in = csq_pkg::STATUS_QUEUED;
                     end
                  end
                  csq_pkg::FUNC_SIGNAL: begin
                     res_status_in = csq_pkg::STATUS_RAISED;
                  end
                  csq_pkg::FUNC_WITHDRAW: begin
                     res_status_in = csq_pkg::STATUS_WITHDRAWN;
                  end
                  csq_pkg::FUNC_CANCEL: begin
                     do_cancel     = 1'b1;
                     res_status_in = csq_pkg::STATUS_CANCELLED;
                  end
                  default: begin
                     res_status_in = csq_pkg::STATUS_TRY_FAILED;
                  end
               endcase
            end else if (csr_wr_en && occ_ff == '0) begin
               sem_in = csr_wr_data;
            end
         end
         csq_pkg::ST_SIGNAL: begin
            if (occ_ff == '0) begin
               res_status_in = csq_pkg::STATUS_RAISED;
               if (sem_ff != csq_pkg::COUNT_MAX) begin
                  sem_in = sem_ff + CW'(1);
               end
            end else begin
               do_shift = 1'b1;
               occ_in   = occ_ff - OCC_W'(1);
               if (cell_valid[0]) begin
                  res_status_in = csq_pkg::STATUS_WOKEN;
                  res_woken_in  = cell_id[0];
               end
            end
         end
         csq_pkg::ST_WITHDRAW: begin
            // full rotation; first live match is dropped on its way round
            do_shift   = 1'b1;
            tail_valid = cell_valid[0] && !kill;
            if (kill) begin
               found_in = 1'b1;
               if (step_ff == '0) begin
                  pop_in = 1'b1;
               end
            end
            step_in = last_step ? '0 : step_ff + STEP_W'(1);
         end
         csq_pkg::ST_POP: begin
            do_shift = 1'b1;
            occ_in   = occ_ff - OCC_W'(1);
         end
         csq_pkg::ST_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_woken_in  = rsp_woken_ff;
      rsp_count_in  = rsp_count_ff;
      if (state_ff == csq_pkg::ST_EMIT && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_woken_in  = res_woken_ff;
         rsp_count_in  = sem_ff;
      end
   end

   always_comb begin
      rsp_tdata                      = '0;
      rsp_tdata[SW-1:0]              = rsp_status_ff;
      rsp_tdata[SW +: ID_BITS]       = rsp_woken_ff;
      rsp_tdata[SW + ID_BITS +: CW]  = rsp_count_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csq_pkg::ST_IDLE;
         sem_ff       <= '0;
         occ_ff       <= '0;
         step_ff      <= '0;
         found_ff     <= 1'b0;
         pop_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sem_ff       <= sem_in;
         occ_ff       <= occ_in;
         step_ff      <= step_in;
         found_ff     <= found_in;
         pop_ff       <= pop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tid_ff        <= tid_in;
      res_status_ff <= res_status_in;
      res_woken_ff  <= res_woken_in;
      rsp_status_ff <= rsp_status_in;
      rsp_woken_ff  <= rsp_woken_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule

// ===== hw/rtl/csq_checker.sv =====
// ----------------------------------------------------------------------------
// csq_checker
// Port-level checks for the counting semaphore, bound to the top level.
// ----------------------------------------------------------------------------
module csq_checker #(
   parameter int ID_BITS = csq_pkg::DEF_ID_BITS,
   parameter int RSP_W   = 32
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   localparam int SW = csq_pkg::STATUS_W;
   localparam int CW = csq_pkg::COUNT_W;

   logic [SW-1:0]      status;
   logic [ID_BITS-1:0] woken;
   logic [CW-1:0]      count;

   assign status = rsp_tdata[SW-1:0];
   assign woken  = rsp_tdata[SW +: ID_BITS];
   assign count  = rsp_tdata[SW + ID_BITS +: CW];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request beat taken while one is in flight");

   a_woken_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status != csq_pkg::STATUS_WOKEN |-> woken == '0)
      else $error("woken thread set without a wake");

   a_acquire_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == csq_pkg::STATUS_ACQUIRED |-> count != csq_pkg::COUNT_MAX)
      else $error("acquire left count at maximum");

   a_raise_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == csq_pkg::STATUS_RAISED |-> count != '0)
      else $error("raise left count at zero");

endmodule

bind counting_semaphore_wait_queue csq_checker #(
   .ID_BITS (ID_BITS),
   .RSP_W   (RSP_W)
) u_csq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
